### hdl/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk_i, disabled while rst_ni is low
`define XHL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form of the above
`define XHL_ASSERT_IMP(lbl, ante, cons, msg) \
  `XHL_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### hdl/xhl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xhl_pkg
// Types and constants of the markup highlight lexer.
// ----------------------------------------------------------------------------
package xhl_pkg;

  localparam int unsigned LookaheadBytes = 9;
  localparam int unsigned MaxLineBytes   = 4096;
  localparam int unsigned FillW          = 5;

  typedef enum logic [2:0] {
    MODE_TEXT    = 3'd0,
    MODE_TAG     = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_CDATA   = 3'd3,
    MODE_DECL    = 3'd4,
    MODE_DQUOTE  = 3'd5,
    MODE_SQUOTE  = 3'd6
  } mode_e;

  typedef enum logic [3:0] {
    KIND_NONE    = 4'd0,
    KIND_TEXT    = 4'd1,
    KIND_PUNCT   = 4'd2,
    KIND_TAG     = 4'd3,
    KIND_OPER    = 4'd4,
    KIND_ATTR    = 4'd5,
    KIND_STRING  = 4'd6,
    KIND_COMMENT = 4'd7,
    KIND_DECL    = 4'd8
  } kind_e;

  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChQuest  = 8'h3F;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChRBrack = 8'h5D;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChDQuote = 8'h22;
  localparam logic [7:0] ChSQuote = 8'h27;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSpace  = 8'h20;

  // "CDATA[" after "<!["
  localparam logic [5:0][7:0] CdataTail = {8'h5B, 8'h41, 8'h54, 8'h41, 8'h44, 8'h43};

  typedef struct packed {
    logic             last;
    logic [FillW-1:0] fill;
  } item_ctrl_t;

endpackage

### hdl/xhl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xhl_front
// Lookahead window: collects request bytes and snapshots the head for lexing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module xhl_front #(
  parameter int unsigned LA = xhl_pkg::LookaheadBytes
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              text_byte_i,
  input  logic                    line_end_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output logic [LA-1:0][7:0]      push_bytes_o,
  output xhl_pkg::item_ctrl_t     push_ctrl_o
);
  import xhl_pkg::*;

  logic [LA-1:0][7:0] win_q, win_d, win_app;
  logic [FillW-1:0]   fill_q, fill_d;
  logic               flush_q, flush_d;
  logic               accept;

  function automatic logic [LA-1:0][7:0] shift_win(input logic [LA-1:0][7:0] src);
    logic [LA-1:0][7:0] r;
    r = src;
    for (int i = 0; i < LA - 1; i++) r[i] = src[i+1];
    return r;
  endfunction

  assign in_stall_o = flush_q | q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    for (int i = 0; i < LA; i++) begin
      win_app[i] = (FillW'(i) == fill_q) ? text_byte_i : win_q[i];
    end
  end

  always_comb begin
    win_d        = win_q;
    fill_d       = fill_q;
    flush_d      = flush_q;
    push_o       = 1'b0;
    push_bytes_o = win_q;
    push_ctrl_o  = '{last: 1'b0, fill: fill_q};
    if (flush_q) begin
      if (!q_full_i) begin
        push_o           = 1'b1;
        push_ctrl_o.last = (fill_q == FillW'(1));
        win_d            = shift_win(win_q);
        fill_d           = fill_q - FillW'(1);
        if (fill_q == FillW'(1)) flush_d = 1'b0;
      end
    end else if (accept) begin
      if (line_end_i) begin
        win_d   = win_app;
        fill_d  = fill_q + FillW'(1);
        flush_d = 1'b1;
      end else if (fill_q == FillW'(LA - 1)) begin
        push_o           = 1'b1;
        push_bytes_o     = win_app;
        push_ctrl_o.fill = FillW'(LA);
        win_d            = shift_win(win_app);
      end else begin
        win_d  = win_app;
        fill_d = fill_q + FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      flush_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      flush_q <= flush_d;
    end
  end

  `XHL_ASSERT(a_fill_bound, fill_q <= FillW'(LA), "window overfilled")
  `XHL_ASSERT_IMP(a_flush_nonempty, flush_q, fill_q != '0, "flush with empty window")
  `XHL_ASSERT_IMP(a_last_on_flush, push_o && push_ctrl_o.last, flush_q && !flush_d,
                  "last byte pushed without ending flush")
endmodule

### hdl/xhl_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xhl_fifo
// Two-entry queue between window and lexer.
// ----------------------------------------------------------------------------
module xhl_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         pop_i,
  output logic [W-1:0] pop_data_o
);
  logic [1:0][W-1:0] mem_q;
  logic              wr_q, rd_q;
  logic [1:0]        cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

### hdl/xhl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xhl_back
// Lexer: classifies each window head and holds the result register.
// ----------------------------------------------------------------------------
module xhl_back #(
  parameter int unsigned LA       = xhl_pkg::LookaheadBytes,
  parameter int unsigned MAX_LINE = xhl_pkg::MaxLineBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                pop_o,
  input  logic [LA-1:0][7:0]  q_bytes_i,
  input  xhl_pkg::item_ctrl_t q_ctrl_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [3:0]          token_kind_o,
  output logic                token_start_o,
  output logic [11:0]         byte_offset_o,
  output logic                last_of_line_o,
  output logic [2:0]          mode_after_o
);
  import xhl_pkg::*;

  localparam int unsigned PW = $clog2(MAX_LINE);

  mode_e         mode_q, mode_d;
  logic [3:0]    frem_q, frem_d;
  kind_e         fkind_q, fkind_d, prev_q, prev_d;
  logic          nopen_q, nopen_d, fresh_q, fresh_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          ovalid_q;
  kind_e         kind;
  logic          start, done;
  logic [7:0]    c;
  logic [FillW-1:0] f;
  logic          is_letter, is_attr, is_name, is_space;
  logic          m_com, m_cdata, m_decl, m_empty, c_com, c_cdata, c_decl;

  assign c = q_bytes_i[0];
  assign f = q_ctrl_i.fill;
  assign is_letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_attr   = is_letter || c == ChUnder;
  assign is_name   = is_attr || (c >= 8'h30 && c <= 8'h39) || c == ChColon || c == ChDash;
  assign is_space  = c == ChSpace || (c >= 8'd9 && c <= 8'd13);

  assign m_com   = f >= FillW'(4) && c == ChLt && q_bytes_i[1] == ChBang
                   && q_bytes_i[2] == ChDash && q_bytes_i[3] == ChDash;
  assign m_cdata = f >= FillW'(9) && c == ChLt && q_bytes_i[1] == ChBang
                   && q_bytes_i[2] == ChLBrack && q_bytes_i[8:3] == CdataTail;
  assign m_decl  = f >= FillW'(2) && c == ChLt && q_bytes_i[1] == ChQuest;
  assign m_empty = f >= FillW'(2) && c == ChSlash && q_bytes_i[1] == ChGt;
  assign c_com   = f >= FillW'(3) && c == ChDash && q_bytes_i[1] == ChDash
                   && q_bytes_i[2] == ChGt;
  assign c_cdata = f >= FillW'(3) && c == ChRBrack && q_bytes_i[1] == ChRBrack
                   && q_bytes_i[2] == ChGt;
  assign c_decl  = f >= FillW'(2) && c == ChQuest && q_bytes_i[1] == ChGt;

  assign pop_o       = q_valid_i && (!ovalid_q || !out_stall_i);
  assign out_valid_o = ovalid_q;

  always_comb begin
    mode_d  = mode_q;
    frem_d  = frem_q;
    fkind_d = fkind_q;
    nopen_d = nopen_q;
    kind    = KIND_NONE;
    start   = 1'b0;
    done    = 1'b0;
    if (frem_q != 4'd0) begin
      kind   = fkind_q;
      frem_d = frem_q - 4'd1;
      done   = 1'b1;
    end else if (nopen_q) begin
      if (is_name) begin
        kind  = (prev_q == KIND_ATTR) ? KIND_ATTR : KIND_TAG;
        start = (prev_q != kind);
        done  = 1'b1;
      end else begin
        nopen_d = 1'b0;
      end
    end
    if (!done) begin
      case (mode_q)
        MODE_TEXT: begin
          if (c == ChLt) begin
            start = 1'b1;
            if (m_com) begin
              kind = KIND_COMMENT; frem_d = 4'd3; fkind_d = KIND_COMMENT;
              mode_d = MODE_COMMENT;
            end else if (m_cdata) begin
              kind = KIND_STRING; frem_d = 4'd8; fkind_d = KIND_STRING;
              mode_d = MODE_CDATA;
            end else if (m_decl) begin
              kind = KIND_DECL; frem_d = 4'd1; fkind_d = KIND_DECL;
              mode_d = MODE_DECL;
            end else begin
              kind    = KIND_PUNCT;
              frem_d  = (f >= FillW'(2) && q_bytes_i[1] == ChSlash) ? 4'd1 : 4'd0;
              fkind_d = KIND_PUNCT;
              nopen_d = 1'b1;
              mode_d  = MODE_TAG;
            end
          end else begin
            kind  = KIND_TEXT;
            start = fresh_q || prev_q != KIND_TEXT;
          end
        end
        MODE_TAG: begin
          if (is_space) begin
            kind = KIND_NONE;
          end else if (c == ChGt) begin
            kind = KIND_PUNCT; start = 1'b1; mode_d = MODE_TEXT;
          end else if (m_empty) begin
            kind = KIND_PUNCT; start = 1'b1; frem_d = 4'd1; fkind_d = KIND_PUNCT;
            mode_d = MODE_TEXT;
          end else if (c == ChEq) begin
            kind = KIND_OPER; start = 1'b1;
          end else if (c == ChDQuote || c == ChSQuote) begin
            kind = KIND_STRING; start = 1'b1;
            mode_d = (c == ChDQuote) ? MODE_DQUOTE : MODE_SQUOTE;
          end else if (is_attr) begin
            kind = KIND_ATTR; start = 1'b1; nopen_d = 1'b1;
          end else begin
            kind = KIND_OPER; start = 1'b1;
          end
        end
        MODE_COMMENT: begin
          kind = KIND_COMMENT; start = fresh_q;
          if (c_com) begin
            frem_d = 4'd2; fkind_d = KIND_COMMENT; mode_d = MODE_TEXT;
          end
        end
        MODE_CDATA: begin
          kind = KIND_STRING; start = fresh_q;
          if (c_cdata) begin
            frem_d = 4'd2; fkind_d = KIND_STRING; mode_d = MODE_TEXT;
          end
        end
        MODE_DECL: begin
          kind = KIND_DECL; start = fresh_q;
          if (c_decl) begin
            frem_d = 4'd1; fkind_d = KIND_DECL; mode_d = MODE_TEXT;
          end
        end
        MODE_DQUOTE: begin
          kind = KIND_STRING; start = fresh_q;
          if (c == ChDQuote) mode_d = MODE_TAG;
        end
        MODE_SQUOTE: begin
          kind = KIND_STRING; start = fresh_q;
          if (c == ChSQuote) mode_d = MODE_TAG;
        end
        default: begin
          kind = KIND_NONE;
        end
      endcase
    end
    prev_d  = kind;
    fresh_d = 1'b0;
    pos_d   = (pos_q == PW'(MAX_LINE - 1)) ? '0 : pos_q + PW'(1);
    if (q_ctrl_i.last) begin
      frem_d  = 4'd0;
      nopen_d = 1'b0;
      prev_d  = KIND_NONE;
      pos_d   = '0;
      fresh_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      token_kind_o   <= kind;
      token_start_o  <= start;
      byte_offset_o  <= 12'(pos_q);
      last_of_line_o <= q_ctrl_i.last;
      mode_after_o   <= q_ctrl_i.last ? mode_d : 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_TEXT;
      frem_q   <= 4'd0;
      fkind_q  <= KIND_NONE;
      nopen_q  <= 1'b0;
      prev_q   <= KIND_NONE;
      pos_q    <= '0;
      fresh_q  <= 1'b1;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q  <= mode_d;
        frem_q  <= frem_d;
        fkind_q <= fkind_d;
        nopen_q <= nopen_d;
        prev_q  <= prev_d;
        pos_q   <= pos_d;
        fresh_q <= fresh_d;
      end
      if (pop_o) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
    end
  end
endmodule

### hdl/xml_highlight_lexer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_highlight_lexer_core
// Markup syntax highlight tokenizer, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel: text_byte_i with line_end_i on the last byte of a line,
//  qualified by in_valid_i, held off by in_stall_o.
//  Output channel: one request per byte with its token kind, start flag,
//  offset in line, last-of-line flag and the mode after the line.
//  A result appears once LA bytes are buffered, i.e. LA-1 requests behind the
//  input; the window is written into the queue and then loaded into the
//  output register. Throughput is one byte per cycle unless stalled. After a
//  line end the window drains one byte per cycle while the queue has room,
//  during which input is stalled. A stalled output holds its result; the
//  two-entry queue then fills and the stall reaches the input.
//  Reset clears the window fill, the queue and all lexer state (text mode).
// ----------------------------------------------------------------------------
module xml_highlight_lexer_core #(
  parameter int unsigned LOOKAHEAD_BYTES = xhl_pkg::LookaheadBytes,
  parameter int unsigned MAX_LINE_BYTES  = xhl_pkg::MaxLineBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        line_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic        token_start_o,
  output logic [11:0] byte_offset_o,
  output logic        last_of_line_o,
  output logic [2:0]  mode_after_o
);
  import xhl_pkg::*;

  localparam int unsigned QW = LOOKAHEAD_BYTES * 8 + $bits(item_ctrl_t);

  logic                            push, q_full, q_valid, pop;
  logic [LOOKAHEAD_BYTES-1:0][7:0] push_bytes, pop_bytes;
  item_ctrl_t                      push_ctrl, pop_ctrl;

  xhl_front #(.LA(LOOKAHEAD_BYTES)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .text_byte_i, .line_end_i,
    .q_full_i(q_full), .push_o(push), .push_bytes_o(push_bytes), .push_ctrl_o(push_ctrl)
  );

  xhl_fifo #(.W(QW)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i({push_ctrl, push_bytes}), .full_o(q_full),
    .valid_o(q_valid), .pop_i(pop), .pop_data_o({pop_ctrl, pop_bytes})
  );

  xhl_back #(.LA(LOOKAHEAD_BYTES), .MAX_LINE(MAX_LINE_BYTES)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .pop_o(pop), .q_bytes_i(pop_bytes),
    .q_ctrl_i(pop_ctrl), .out_valid_o, .out_stall_i, .token_kind_o, .token_start_o,
    .byte_offset_o, .last_of_line_o, .mode_after_o
  );
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the markup highlight lexer against a behavioral tokenizer. Lines of
// markup fragments and random bytes stream in; each classified byte is
// compared with the predicted token kind, start flag, offset and line mode.
// ----------------------------------------------------------------------------
import xhl_pkg::*;

typedef struct packed {
  logic [3:0]  kind;
  logic        start;
  logic [11:0] offset;
  logic        last;
  logic [2:0]  mode;
} token_t;

class token_scoreboard;
  token_t      pending[$];
  int unsigned errors;
  int unsigned checked;
  mode_e       mode;
  logic [7:0]  win[LookaheadBytes];
  int unsigned fill;
  int unsigned forced_cnt;
  kind_e       forced_kind;
  bit          name_open;
  kind_e       prev_kind;
  logic [11:0] pos;
  bit          fresh;

  function new();
    mode = MODE_TEXT;
    fill = 0;
    forced_cnt = 0;
    forced_kind = KIND_NONE;
    name_open = 0;
    prev_kind = KIND_NONE;
    pos = 0;
    fresh = 1;
  endfunction

  function bit seq_at(string s);
    if (s.len() > fill) return 0;
    for (int i = 0; i < s.len(); i++) if (win[i] != s[i]) return 0;
    return 1;
  endfunction

  function bit name_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == ChUnder ||
           (c >= "0" && c <= "9") || c == ChColon || c == ChDash;
  endfunction

  function bit attr_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == ChUnder;
  endfunction

  function void classify_head(bit last);
    logic [7:0] c;
    kind_e k;
    bit st;
    bit done;
    token_t t;
    c = win[0];
    k = KIND_NONE;
    st = 0;
    done = 0;
    if (forced_cnt != 0) begin
      k = forced_kind;
      forced_cnt--;
      done = 1;
    end else if (name_open) begin
      if (name_ch(c)) begin
        k = (prev_kind == KIND_ATTR) ? KIND_ATTR : KIND_TAG;
        st = (prev_kind != k);
        done = 1;
      end else begin
        name_open = 0;
      end
    end
    if (!done) begin
      case (mode)
        MODE_TEXT: begin
          if (c == ChLt) begin
            st = 1;
            if (seq_at("<!--")) begin
              k = KIND_COMMENT; forced_cnt = 3; forced_kind = KIND_COMMENT;
              mode = MODE_COMMENT;
            end else if (seq_at("<![CDATA[")) begin
              k = KIND_STRING; forced_cnt = 8; forced_kind = KIND_STRING;
              mode = MODE_CDATA;
            end else if (seq_at("<?")) begin
              k = KIND_DECL; forced_cnt = 1; forced_kind = KIND_DECL;
              mode = MODE_DECL;
            end else begin
              k = KIND_PUNCT;
              forced_cnt = (fill >= 2 && win[1] == ChSlash) ? 1 : 0;
              forced_kind = KIND_PUNCT;
              name_open = 1;
              mode = MODE_TAG;
            end
          end else begin
            k = KIND_TEXT;
            st = fresh || prev_kind != KIND_TEXT;
          end
        end
        MODE_TAG: begin
          if (c == ChSpace || (c >= 9 && c <= 13)) k = KIND_NONE;
          else if (c == ChGt) begin
            k = KIND_PUNCT; st = 1; mode = MODE_TEXT;
          end else if (seq_at("/>")) begin
            k = KIND_PUNCT; st = 1; forced_cnt = 1; forced_kind = KIND_PUNCT;
            mode = MODE_TEXT;
          end else if (c == ChEq) begin
            k = KIND_OPER; st = 1;
          end else if (c == ChDQuote || c == ChSQuote) begin
            k = KIND_STRING; st = 1;
            mode = (c == ChDQuote) ? MODE_DQUOTE : MODE_SQUOTE;
          end else if (attr_ch(c)) begin
            k = KIND_ATTR; st = 1; name_open = 1;
          end else begin
            k = KIND_OPER; st = 1;
          end
        end
        MODE_COMMENT: begin
          k = KIND_COMMENT; st = fresh;
          if (seq_at("-->")) begin
            forced_cnt = 2; forced_kind = KIND_COMMENT; mode = MODE_TEXT;
          end
        end
        MODE_CDATA: begin
          k = KIND_STRING; st = fresh;
          if (seq_at("]]>")) begin
            forced_cnt = 2; forced_kind = KIND_STRING; mode = MODE_TEXT;
          end
        end
        MODE_DECL: begin
          k = KIND_DECL; st = fresh;
          if (seq_at("?>")) begin
            forced_cnt = 1; forced_kind = KIND_DECL; mode = MODE_TEXT;
          end
        end
        MODE_DQUOTE, MODE_SQUOTE: begin
          k = KIND_STRING; st = fresh;
          if (c == ((mode == MODE_DQUOTE) ? ChDQuote : ChSQuote)) mode = MODE_TAG;
        end
        default: k = KIND_NONE;
      endcase
    end
    t.kind = k;
    t.start = st;
    t.offset = pos;
    t.last = last;
    t.mode = last ? mode : 3'd0;
    pending.push_back(t);
    prev_kind = k;
    fresh = 0;
    pos++;
    for (int i = 0; i + 1 < LookaheadBytes; i++) win[i] = win[i + 1];
    if (fill > 0) fill--;
  endfunction

  function void note_request(logic [7:0] b, logic eol);
    if (fill < LookaheadBytes) begin
      win[fill] = b;
      fill++;
    end
    if (eol) begin
      while (fill > 0) classify_head(fill == 1);
      forced_cnt = 0;
      name_open = 0;
      prev_kind = KIND_NONE;
      pos = 0;
      fresh = 1;
    end else if (fill >= LookaheadBytes) begin
      classify_head(0);
    end
  endfunction

  function void check_result(token_t got);
    token_t exp_t;
    checked++;
    if (pending.size() == 0) begin
      $error("unexpected result kind=%0d offset=%0d", got.kind, got.offset);
      errors++;
      return;
    end
    exp_t = pending.pop_front();
    if (got.kind !== exp_t.kind) begin
      $error("token_kind: expected %0d, got %0d", exp_t.kind, got.kind); errors++;
    end
    if (got.start !== exp_t.start) begin
      $error("token_start: expected %0d, got %0d", exp_t.start, got.start); errors++;
    end
    if (got.offset !== exp_t.offset) begin
      $error("byte_offset: expected %0d, got %0d", exp_t.offset, got.offset); errors++;
    end
    if (got.last !== exp_t.last) begin
      $error("last_of_line: expected %0d, got %0d", exp_t.last, got.last); errors++;
    end
    if (got.mode !== exp_t.mode) begin
      $error("mode_after: expected %0d, got %0d", exp_t.mode, got.mode); errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned WatchdogLimit = 5000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [7:0]  text_byte_i = 0;
  logic        line_end_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [3:0]  token_kind_o;
  logic        token_start_o;
  logic [11:0] byte_offset_o;
  logic        last_of_line_o;
  logic [2:0]  mode_after_o;

  token_scoreboard sb = new();
  int unsigned sent_bytes;
  int unsigned line_count;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned stall_mode;
  bit          stall_on = 0;

  always #10 clk_i = ~clk_i;

  xml_highlight_lexer_core u_dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_request(text_byte_i, line_end_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({token_kind_o, token_start_o, byte_offset_o, last_of_line_o,
                       mode_after_o});
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall pattern: phases of no stalls, random stalls and random stall bursts
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: begin
        if ($urandom_range(0, 7) == 0) stall_on = ~stall_on;
        out_stall_i <= stall_on;
      end
    endcase
  end

  task automatic send_byte(logic [7:0] b, logic eol);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid_i <= 0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i <= 1;
    text_byte_i <= b;
    line_end_i <= eol;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_bytes++;
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    line_count++;
  endtask

  function automatic string rand_fragment();
    string f[$] = '{"<a href=\"x\">", "<!-- c -->", "<![CDATA[ d ]]>", "<?xml v?>",
                    "</b>", "<br/>", "text ", "<t k='v' x=1>", "<!--", "-->", "]]>",
                    "?>", "<", "</", "<![CDATA[", "<?", "'", "\"", " = ", "\t"};
    return f[$urandom_range(0, f.size() - 1)];
  endfunction

  initial begin
    string s;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_line("<root attr=\"v\" b='w'>hi</root>");
    send_line("<!-- open");
    send_line("close --><![CDATA[ x");
    send_line("]]><?pi x?><e/><>< /x>");
    send_byte(8'hFF, 0); send_byte(8'h00, 0); send_byte(8'h80, 0); send_byte(8'h7F, 1);
    send_line("<!-");
    send_line("a");
    while (sent_bytes < 170) begin
      s = "";
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 12)) s = {s, string'(8'($urandom_range(0, 255)))};
      end else begin
        repeat ($urandom_range(1, 5)) s = {s, rand_fragment()};
      end
      send_line(s);
    end
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("Sent %0d bytes in %0d lines, checked %0d classified bytes.",
             sent_bytes, line_count, sb.checked);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
